### rtl/rbap_pkg.sv
// shared types and constants for the bulk string array parser
package rbap_pkg;

  typedef enum logic [3:0] {
    PH_STAR,
    PH_CNT,
    PH_CNT_SKIP,
    PH_DOLLAR,
    PH_LEN,
    PH_LEN_SKIP,
    PH_PAYLOAD,
    PH_TRAIL1,
    PH_TRAIL2,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_STAR,
    ST_NO_DOLLAR,
    ST_TRUNC
  } status_t;

  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  typedef struct packed {
    logic [7:0]  token_byte;
    logic        byte_valid;
    logic        token_done;
    logic        empty_token;
    logic [15:0] token_index;
    logic        message_done;
    logic [15:0] token_total;
    status_t     parse_status;
  } res_t;

endpackage

### rtl/rbap_step.sv
// next parser state and result for one message byte
module rbap_step #(
  parameter int COUNT_BITS  = 16,
  parameter int LENGTH_BITS = 16
) (
  input  logic [7:0]             in_byte,
  input  logic                   last_byte,
  input  rbap_pkg::phase_t       phase,
  input  logic [COUNT_BITS-1:0]  count_target,
  input  logic [COUNT_BITS-1:0]  tokens_seen,
  input  logic [LENGTH_BITS-1:0] length_left,
  input  rbap_pkg::status_t      stop_status,
  output rbap_pkg::phase_t       phase_next,
  output logic [COUNT_BITS-1:0]  count_target_next,
  output logic [COUNT_BITS-1:0]  tokens_seen_next,
  output logic [LENGTH_BITS-1:0] length_left_next,
  output rbap_pkg::status_t      stop_status_next,
  output rbap_pkg::res_t         res
);
  import rbap_pkg::*;

  phase_t                 ph;
  logic [COUNT_BITS-1:0]  cnt;
  logic [COUNT_BITS-1:0]  seen;
  logic [COUNT_BITS-1:0]  seen_inc;
  logic [LENGTH_BITS-1:0] len;
  status_t                st;
  logic                   dig;
  logic                   eod;
  logic [31:0]            seen_wide;
  logic [31:0]            total_wide;

  function automatic logic [COUNT_BITS-1:0] sat_cnt(input logic [COUNT_BITS-1:0] a,
                                                    input logic [3:0] d);
    logic [COUNT_BITS+3:0] v;
    v = (COUNT_BITS+4)'({a, 3'b000}) + (COUNT_BITS+4)'({a, 1'b0})
        + (COUNT_BITS+4)'(d);
    return (|v[COUNT_BITS+3:COUNT_BITS]) ? '1 : v[COUNT_BITS-1:0];
  endfunction

  function automatic logic [LENGTH_BITS-1:0] sat_len(input logic [LENGTH_BITS-1:0] a,
                                                     input logic [3:0] d);
    logic [LENGTH_BITS+3:0] v;
    v = (LENGTH_BITS+4)'({a, 3'b000}) + (LENGTH_BITS+4)'({a, 1'b0})
        + (LENGTH_BITS+4)'(d);
    return (|v[LENGTH_BITS+3:LENGTH_BITS]) ? '1 : v[LENGTH_BITS-1:0];
  endfunction

  assign dig       = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
  assign seen_wide = 32'(tokens_seen);
  assign seen_inc  = tokens_seen + 1'b1;

  always_comb begin
    ph   = phase;
    cnt  = count_target;
    seen = tokens_seen;
    len  = length_left;
    st   = stop_status;
    res  = '0;
    eod  = 1'b0;
    total_wide = '0;

    if (phase != PH_DONE && in_byte != CHAR_NUL) begin
      case (phase)
        PH_STAR: begin
          if (in_byte == CHAR_STAR) begin
            ph = PH_CNT;
          end else begin
            st = ST_NO_STAR;
            ph = PH_DONE;
          end
        end
        PH_CNT: begin
          if (dig) begin
            cnt = sat_cnt(count_target, in_byte[3:0]);
          end else if (count_target == '0) begin
            st = ST_OK;
            ph = PH_DONE;
          end else begin
            ph = PH_CNT_SKIP;
          end
        end
        PH_CNT_SKIP, PH_TRAIL2: begin
          ph = PH_DOLLAR;
        end
        PH_TRAIL1: begin
          ph = PH_TRAIL2;
        end
        PH_DOLLAR: begin
          if (in_byte == CHAR_DOLLAR) begin
            len = '0;
            ph  = PH_LEN;
          end else begin
            st = ST_NO_DOLLAR;
            ph = PH_DONE;
          end
        end
        PH_LEN: begin
          if (dig) begin
            len = sat_len(length_left, in_byte[3:0]);
          end else begin
            ph = PH_LEN_SKIP;
          end
        end
        PH_LEN_SKIP: begin
          if (length_left == '0) begin
            res.token_done  = 1'b1;
            res.empty_token = 1'b1;
            res.token_index = seen_wide[15:0];
            seen = seen_inc;
            if (seen_inc >= count_target) begin
              ph = PH_DONE;
              st = ST_OK;
            end else begin
              ph = PH_TRAIL1;
            end
          end else begin
            ph = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          res.token_byte  = in_byte;
          res.byte_valid  = 1'b1;
          res.token_index = seen_wide[15:0];
          if (length_left != '0) begin
            len = length_left - 1'b1;
          end
          if (len == '0) begin
            res.token_done = 1'b1;
            seen = seen_inc;
            if (seen_inc >= count_target) begin
              ph = PH_DONE;
              st = ST_OK;
            end else begin
              ph = PH_TRAIL1;
            end
          end
        end
        default: begin
          ph = PH_DONE;
        end
      endcase
    end

    eod = (ph != PH_DONE) && (in_byte == CHAR_NUL || last_byte);

    // end of data: a finished zero length still closes an empty token
    if (eod) begin
      if (ph == PH_STAR) begin
        st = ST_NO_STAR;
      end else if ((ph == PH_LEN || ph == PH_LEN_SKIP) && len == '0) begin
        res.token_done  = 1'b1;
        res.empty_token = 1'b1;
        res.token_index = seen_wide[15:0];
        seen = seen_inc;
        if (seen_inc >= cnt) begin
          st = ST_OK;
        end else begin
          st = ST_TRUNC;
        end
      end else begin
        st = ST_TRUNC;
      end
      ph = PH_DONE;
    end

    if (last_byte) begin
      total_wide         = 32'(seen);
      res.message_done   = 1'b1;
      res.token_total    = total_wide[15:0];
      res.parse_status   = st;
      ph   = PH_STAR;
      cnt  = '0;
      seen = '0;
      len  = '0;
      st   = ST_OK;
    end
  end

  assign phase_next        = ph;
  assign count_target_next = cnt;
  assign tokens_seen_next  = seen;
  assign length_left_next  = len;
  assign stop_status_next  = st;

endmodule

### rtl/resp_bulk_array_parser.sv
// top level of the bulk string array parser: input register, parse state and result register
// Parses a byte stream holding an array of length-prefixed bulk strings ('*' count, then
// '$' length tokens) at one byte per clock. Each byte passes an input register, then the
// parse logic updates the state and loads the result register in the same cycle, so a
// result passes the input register, then the result register; a new byte can be taken
// every cycle while the output side keeps up. Every input byte gives exactly one result;
// m_tlast marks the result of the final byte, which carries the status and token total.
module resp_bulk_array_parser #(
  parameter int COUNT_BITS  = 16,
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // token_byte, token_index, token_total, parse_status
  output logic [2:0]  m_tuser,   // byte_valid, token_done, empty_token
  output logic        m_tlast    // message_done
);
  import rbap_pkg::*;

  logic                   in_valid;
  logic [7:0]             in_byte;
  logic                   in_last;
  logic                   adv;

  phase_t                 phase;
  phase_t                 phase_next;
  logic [COUNT_BITS-1:0]  count_target;
  logic [COUNT_BITS-1:0]  count_target_next;
  logic [COUNT_BITS-1:0]  tokens_seen;
  logic [COUNT_BITS-1:0]  tokens_seen_next;
  logic [LENGTH_BITS-1:0] length_left;
  logic [LENGTH_BITS-1:0] length_left_next;
  status_t                stop_status;
  status_t                stop_status_next;
  res_t                   res_next;
  res_t                   res;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = !in_valid || adv;

  rbap_step #(
    .COUNT_BITS  (COUNT_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_step (
    .in_byte           (in_byte),
    .last_byte         (in_last),
    .phase             (phase),
    .count_target      (count_target),
    .tokens_seen       (tokens_seen),
    .length_left       (length_left),
    .stop_status       (stop_status),
    .phase_next        (phase_next),
    .count_target_next (count_target_next),
    .tokens_seen_next  (tokens_seen_next),
    .length_left_next  (length_left_next),
    .stop_status_next  (stop_status_next),
    .res               (res_next)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_STAR;
      count_target <= '0;
      tokens_seen  <= '0;
      length_left  <= '0;
      stop_status  <= ST_OK;
    end else if (in_valid && adv) begin
      phase        <= phase_next;
      count_target <= count_target_next;
      tokens_seen  <= tokens_seen_next;
      length_left  <= length_left_next;
      stop_status  <= stop_status_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= in_valid;
    end
    if (in_valid && adv) begin
      res <= res_next;
    end
  end

  assign m_tdata = {6'b000000, res.parse_status, res.token_total, res.token_index,
                    res.token_byte};
  assign m_tuser = {res.empty_token, res.token_done, res.byte_valid};
  assign m_tlast = res.message_done;

endmodule
